@@ rtl/u2sw_pkg.sv @@
// shared types and constants of the utf-8 to ucs-2 string writer
package u2sw_pkg;

  // input item kinds
  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_BYTE  = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;

  // default depth of the command queue between front and back
  localparam int unsigned Q_DEPTH_DEF = 4;

  localparam logic [15:0] REPLACEMENT = 16'hFFFD;

  // result kinds
  typedef enum logic [1:0] {
    RK_PAD    = 2'd0,
    RK_UNIT   = 2'd1,
    RK_DONE   = 2'd2,
    RK_REJECT = 2'd3
  } rk_t;

  // command opcodes passed from front to back
  typedef enum logic [1:0] {
    OP_START  = 2'd0,
    OP_REJECT = 2'd1,
    OP_DATA   = 2'd2,
    OP_END    = 2'd3
  } op_t;

  // one queued command
  typedef struct packed {
    op_t         op;
    logic [2:0]  repl;    // replacement code units to emit first
    logic        rune;    // a decoded code unit follows
    logic [15:0] cu;      // mapped, truncated code unit
    logic        term;    // terminator wanted (end)
    logic        pad;     // alignment pad byte (start)
    logic [14:0] budget;  // rune budget (start)
  } cmd_t;

endpackage

@@ rtl/u2sw_front.sv @@
// front end: accepts items, decodes utf-8 and queues commands
module u2sw_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [1:0]      in_kind,
  input  logic [7:0]      in_data_byte,
  input  logic [15:0]     in_offset,
  input  logic [15:0]     in_max_length,
  input  logic [14:0]     in_rune_count,
  input  logic            in_upcase_flag,
  input  logic            in_path_flag,
  input  logic            in_revpath_flag,
  input  logic            in_unterminated_flag,
  input  logic            in_unaligned_flag,
  input  logic            convert_space,
  input  logic            q_full,
  output logic            q_push,
  output u2sw_pkg::cmd_t  q_cmd
);
  import u2sw_pkg::*;

  localparam logic [20:0] CH_A     = 21'h61;
  localparam logic [20:0] CH_Z     = 21'h7A;
  localparam logic [20:0] CH_SLASH = 21'h2F;
  localparam logic [20:0] CH_BSL   = 21'h5C;
  localparam logic [20:0] CH_SPACE = 21'h20;
  localparam logic [20:0] CH_NBSP  = 21'hA0;

  function automatic logic [15:0] map_rune(input logic [20:0] r, input logic up,
                                           input logic pth, input logic rev,
                                           input logic cs);
    logic [20:0] m;
    m = r;
    if (up && r >= CH_A && r <= CH_Z) m = r - 21'h20;
    else if (rev && r == CH_SLASH)     m = CH_BSL;
    else if (pth && r == CH_BSL)       m = CH_SLASH;
    else if (rev && cs && r == CH_NBSP) m = CH_SPACE;
    else if (pth && cs && r == CH_SPACE) m = CH_NBSP;
    return m[15:0];
  endfunction

  logic        active_r, active_nxt;
  logic [1:0]  pend_r, pend_nxt;
  logic [20:0] acc_r, acc_nxt;
  logic [1:0]  held_r, held_nxt;
  logic        up_r, up_nxt;
  logic        path_r, path_nxt;
  logic        rev_r, rev_nxt;
  logic        unterm_r, unterm_nxt;

  logic        accept;
  logic        lead2, lead3, lead4, ss_rune, is_cont, bad, align;
  logic [1:0]  ss_pend;
  logic [20:0] ss_acc, ss_val, acc_ext;
  logic [2:0]  seq_len;
  logic [17:0] need;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  // start-of-sequence classification of the incoming byte
  assign lead2   = (in_data_byte[7:5] == 3'b110);
  assign lead3   = (in_data_byte[7:4] == 4'b1110);
  assign lead4   = (in_data_byte[7:3] == 5'b11110);
  assign ss_rune = !(lead2 || lead3 || lead4);
  assign ss_val  = in_data_byte[7] ? {5'd0, REPLACEMENT} : {13'd0, in_data_byte};
  assign ss_pend = lead2 ? 2'd1 : (lead3 ? 2'd2 : (lead4 ? 2'd3 : 2'd0));
  assign ss_acc  = lead2 ? {16'd0, in_data_byte[4:0]} :
                   (lead3 ? {17'd0, in_data_byte[3:0]} : {18'd0, in_data_byte[2:0]});
  assign is_cont = (in_data_byte[7:6] == 2'b10);
  assign acc_ext = {acc_r[14:0], in_data_byte[5:0]};
  assign seq_len = {1'b0, held_r} + 3'd1;

  // overlong and out-of-range checks on a completed sequence
  always_comb begin
    unique case (held_r)
      2'd1:    bad = (acc_ext <= 21'h7F);
      2'd2:    bad = (acc_ext <= 21'h7FF);
      default: bad = (acc_ext <= 21'hFFFF) || (acc_ext > 21'h10FFFF);
    endcase
  end

  // space check on a start item
  assign align = !in_unaligned_flag && in_offset[0];
  assign need  = {2'd0, in_offset} + {2'd0, in_rune_count, 1'b0}
               + (in_unterminated_flag ? 18'd0 : 18'd2) + {17'd0, align};

  always_comb begin
    active_nxt = active_r;
    pend_nxt   = pend_r;
    acc_nxt    = acc_r;
    held_nxt   = held_r;
    up_nxt     = up_r;
    path_nxt   = path_r;
    rev_nxt    = rev_r;
    unterm_nxt = unterm_r;
    q_push     = 1'b0;
    q_cmd      = '0;
    if (accept) begin
      unique case (in_kind)
        KIND_START: begin
          up_nxt     = in_upcase_flag;
          path_nxt   = in_path_flag;
          rev_nxt    = in_revpath_flag;
          unterm_nxt = in_unterminated_flag;
          pend_nxt   = 2'd0;
          acc_nxt    = '0;
          held_nxt   = 2'd0;
          q_push     = 1'b1;
          if (need > {2'd0, in_max_length}) begin
            q_cmd.op   = OP_REJECT;
            active_nxt = 1'b0;
          end else begin
            q_cmd.op     = OP_START;
            q_cmd.pad    = align;
            q_cmd.budget = in_rune_count;
            active_nxt   = 1'b1;
          end
        end
        KIND_BYTE: begin
          q_cmd.op = OP_DATA;
          if (active_r) begin
            if (pend_r == 2'd0 || !is_cont) begin
              // fresh byte; a broken sequence first flushes its held bytes
              q_cmd.repl = (pend_r == 2'd0) ? 3'd0 : {1'b0, held_r};
              if (ss_rune) begin
                q_cmd.rune = 1'b1;
                q_cmd.cu   = map_rune(ss_val, up_r, path_r, rev_r, convert_space);
                pend_nxt   = 2'd0;
                acc_nxt    = '0;
                held_nxt   = 2'd0;
              end else begin
                pend_nxt = ss_pend;
                acc_nxt  = ss_acc;
                held_nxt = 2'd1;
              end
              q_push = ss_rune || (q_cmd.repl != 3'd0);
            end else if (pend_r != 2'd1) begin
              acc_nxt  = acc_ext;
              pend_nxt = pend_r - 2'd1;
              held_nxt = (held_r == 2'd3) ? 2'd3 : held_r + 2'd1;
            end else begin
              pend_nxt = 2'd0;
              acc_nxt  = '0;
              held_nxt = 2'd0;
              q_push   = 1'b1;
              if (bad) begin
                q_cmd.repl = seq_len;
              end else begin
                q_cmd.rune = 1'b1;
                q_cmd.cu   = map_rune(acc_ext, up_r, path_r, rev_r, convert_space);
              end
            end
          end
        end
        KIND_END: begin
          if (active_r) begin
            q_push     = 1'b1;
            q_cmd.op   = OP_END;
            q_cmd.repl = (pend_r == 2'd0) ? 3'd0 : {1'b0, held_r};
            q_cmd.term = !unterm_r;
            pend_nxt   = 2'd0;
            acc_nxt    = '0;
            held_nxt   = 2'd0;
            active_nxt = 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      pend_r   <= 2'd0;
      acc_r    <= '0;
      held_r   <= 2'd0;
      up_r     <= 1'b0;
      path_r   <= 1'b0;
      rev_r    <= 1'b0;
      unterm_r <= 1'b0;
    end else begin
      active_r <= active_nxt;
      pend_r   <= pend_nxt;
      acc_r    <= acc_nxt;
      held_r   <= held_nxt;
      up_r     <= up_nxt;
      path_r   <= path_nxt;
      rev_r    <= rev_nxt;
      unterm_r <= unterm_nxt;
    end
  end

endmodule

@@ rtl/u2sw_queue.sv @@
// short command queue between front and back
module u2sw_queue #(
  parameter int unsigned DEPTH = u2sw_pkg::Q_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  u2sw_pkg::cmd_t  push_cmd,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output u2sw_pkg::cmd_t  head_cmd
);
  import u2sw_pkg::*;

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  cmd_t          entries_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full       = (count_r == CW'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_cmd   = entries_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    if (pop)  rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    unique case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) entries_r[wr_ptr_r] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

@@ rtl/u2sw_back.sv @@
// back end: expands queued commands into results, keeps budget and byte count
module u2sw_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  u2sw_pkg::cmd_t  q_head,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [1:0]      out_result_kind,
  output logic [15:0]     out_code_unit,
  output logic [15:0]     out_bytes_written,
  output logic            out_last
);
  import u2sw_pkg::*;

  logic        busy_r, busy_nxt;
  cmd_t        cur_r, cur_nxt;
  logic [14:0] budget_r, budget_nxt;
  logic [16:0] total_r, total_nxt;

  logic        ov_r, ov_nxt;
  rk_t         kind_r, kind_nxt;
  logic [15:0] cu_r, cu_nxt;
  logic [15:0] bw_r, bw_nxt;
  logic        last_r, last_nxt;

  logic        out_ok, go, emit, done_step, more;
  cmd_t        eff, rem;
  rk_t         e_kind;
  logic [15:0] e_cu, e_bw, unit;
  logic        e_last;

  assign out_ok = !ov_r || !out_stall;
  assign go     = out_ok && (busy_r || q_valid);
  assign eff    = busy_r ? cur_r : q_head;
  assign q_pop  = go && !busy_r;

  // one step of the current command
  always_comb begin
    rem        = eff;
    emit       = 1'b0;
    e_kind     = RK_UNIT;
    e_cu       = '0;
    e_bw       = '0;
    e_last     = 1'b0;
    done_step  = 1'b0;
    unit       = eff.cu;
    budget_nxt = budget_r;
    total_nxt  = total_r;
    unique case (eff.op)
      OP_START: begin
        budget_nxt = eff.budget;
        total_nxt  = {16'd0, eff.pad};
        emit       = eff.pad;
        e_kind     = RK_PAD;
      end
      OP_REJECT: begin
        budget_nxt = '0;
        total_nxt  = '0;
        emit       = 1'b1;
        e_kind     = RK_REJECT;
        e_last     = 1'b1;
      end
      OP_DATA, OP_END: begin
        if (eff.repl != 3'd0 || eff.rune) begin
          if (eff.repl != 3'd0) begin
            rem.repl = eff.repl - 3'd1;
            unit     = REPLACEMENT;
          end else begin
            rem.rune = 1'b0;
          end
          // runes past the budget are dropped
          if (budget_r != '0) begin
            emit       = 1'b1;
            e_cu       = unit;
            budget_nxt = budget_r - 15'd1;
            total_nxt  = total_r + 17'd2;
          end
        end else if (eff.term) begin
          rem.term  = 1'b0;
          emit      = 1'b1;
          total_nxt = total_r + 17'd2;
        end else if (eff.op == OP_END) begin
          done_step = 1'b1;
          emit      = 1'b1;
          e_kind    = RK_DONE;
          e_bw      = total_r[15:0];
          e_last    = 1'b1;
        end
      end
      default: ;
    endcase
    more = (rem.repl != 3'd0) || rem.rune || rem.term ||
           ((eff.op == OP_END) && !done_step);
  end

  always_comb begin
    busy_nxt = busy_r;
    cur_nxt  = cur_r;
    ov_nxt   = ov_r;
    kind_nxt = kind_r;
    cu_nxt   = cu_r;
    bw_nxt   = bw_r;
    last_nxt = last_r;
    if (go) begin
      busy_nxt = more;
      cur_nxt  = rem;
    end
    if (out_ok) begin
      ov_nxt   = go && emit;
      kind_nxt = e_kind;
      cu_nxt   = e_cu;
      bw_nxt   = e_bw;
      last_nxt = e_last;
    end
  end

  assign out_valid         = ov_r;
  assign out_result_kind   = kind_r;
  assign out_code_unit     = cu_r;
  assign out_bytes_written = bw_r;
  assign out_last          = last_r;

  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    kind_r <= kind_nxt;
    cu_r   <= cu_nxt;
    bw_r   <= bw_nxt;
    last_r <= last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      ov_r     <= 1'b0;
      budget_r <= '0;
      total_r  <= '0;
    end else begin
      busy_r   <= busy_nxt;
      ov_r     <= ov_nxt;
      if (go) begin
        budget_r <= budget_nxt;
        total_r  <= total_nxt;
      end
    end
  end

endmodule

@@ rtl/utf8_to_ucs2_string_writer_unit.sv @@
// top level of the utf-8 to ucs-2 string writer
// path: the first result of a transaction passes the command queue and is then
//   registered in the back end output register before it can be taken
// throughput: one input transaction per cycle while the command queue has room; the back
//   end spends one step per result, per dropped over-budget rune and per start without pad
// reset: synchronous active-low rst_n clears decoder, queue, budget and output valid
module utf8_to_ucs2_string_writer_unit #(
  parameter int unsigned QUEUE_DEPTH = u2sw_pkg::Q_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_write_en,
  input  logic        cfg_write_data,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic [7:0]  in_data_byte,
  input  logic [15:0] in_offset,
  input  logic [15:0] in_max_length,
  input  logic [14:0] in_rune_count,
  input  logic        in_upcase_flag,
  input  logic        in_path_flag,
  input  logic        in_revpath_flag,
  input  logic        in_unterminated_flag,
  input  logic        in_unaligned_flag,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_result_kind,
  output logic [15:0] out_code_unit,
  output logic [15:0] out_bytes_written,
  output logic        out_last
);
  import u2sw_pkg::*;

  // space / no-break space swap enable; user writes it only while idle, unenforced
  logic convert_space_r;

  // front to queue
  logic q_push;
  cmd_t q_cmd;
  logic q_full;

  // queue to back
  logic q_pop;
  logic q_head_valid;
  cmd_t q_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      convert_space_r <= 1'b0;
    end else if (cfg_write_en) begin
      convert_space_r <= cfg_write_data;
    end
  end

  // front: takes transactions, runs the utf-8 decoder and the space check
  u2sw_front u_front (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_kind              (in_kind),
    .in_data_byte         (in_data_byte),
    .in_offset            (in_offset),
    .in_max_length        (in_max_length),
    .in_rune_count        (in_rune_count),
    .in_upcase_flag       (in_upcase_flag),
    .in_path_flag         (in_path_flag),
    .in_revpath_flag      (in_revpath_flag),
    .in_unterminated_flag (in_unterminated_flag),
    .in_unaligned_flag    (in_unaligned_flag),
    .convert_space        (convert_space_r),
    .q_full               (q_full),
    .q_push               (q_push),
    .q_cmd                (q_cmd)
  );

  // decouples decoding from result expansion
  u2sw_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (q_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_cmd   (q_head)
  );

  // back: at most one result per step, tracks rune budget and bytes written
  u2sw_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_head_valid),
    .q_head            (q_head),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_result_kind   (out_result_kind),
    .out_code_unit     (out_code_unit),
    .out_bytes_written (out_bytes_written),
    .out_last          (out_last)
  );

  // last marks exactly the closing results of a string
  a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == (out_result_kind == RK_DONE ||
                                out_result_kind == RK_REJECT)))
    else $error("last flag does not match result kind");

  // the back end never pops an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_head_valid)
    else $error("pop from empty command queue");

  // byte count only travels with a done result
  a_bw_done_only: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_result_kind != RK_DONE) |-> (out_bytes_written == 16'd0))
    else $error("byte count on a result other than done");

endmodule

@@ verif/testbench.sv @@
// self-checking testbench for the utf-8 to ucs-2 string writer unit
`timescale 1ns / 100ps

module testbench;
  import u2sw_pkg::*;

  // kind code that the block must ignore
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  // start-item flag masks, in the order they are latched
  localparam logic [4:0] FLAG_UPCASE  = 5'b00001;
  localparam logic [4:0] FLAG_PATH    = 5'b00010;
  localparam logic [4:0] FLAG_REVPATH = 5'b00100;
  localparam logic [4:0] FLAG_UNTERM  = 5'b01000;
  localparam logic [4:0] FLAG_UNALIGN = 5'b10000;
  localparam logic [4:0] FLAG_MAPPING = FLAG_UPCASE | FLAG_PATH | FLAG_REVPATH;

  // characters the mapping rules look at
  localparam logic [20:0] CH_LOWER_A   = 21'h61;
  localparam logic [20:0] CH_LOWER_Z   = 21'h7A;
  localparam logic [20:0] CASE_GAP     = 21'h20;
  localparam logic [20:0] CH_SLASH     = 21'h2F;
  localparam logic [20:0] CH_BACKSLASH = 21'h5C;
  localparam logic [20:0] CH_SPACE     = 21'h20;
  localparam logic [20:0] CH_NBSP      = 21'hA0;
  localparam logic [20:0] CH_REPLACE   = {5'd0, REPLACEMENT};

  // covers the command queue and the output register plus queued items that produce nothing
  localparam int unsigned SETTLE_CYCLES  = 12;
  // long receiver hold-off, well beyond the command queue depth
  localparam int unsigned HOLD_CYCLES    = 48;
  // cycles with no transaction on either channel before giving up
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned MAX_REPORTS    = 10;

  // one input transaction, every field present whatever the kind
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data;
    logic [15:0] offset;
    logic [15:0] max_len;
    logic [14:0] runes;
    logic [4:0]  flags;
  } txn_t;

  // one expected write into the message buffer
  typedef struct packed {
    rk_t         rk;
    logic [15:0] cu;
    logic [15:0] bw;
    logic        is_last;
  } wr_result_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_write_en;
  logic        cfg_write_data;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_kind;
  logic [7:0]  in_data_byte;
  logic [15:0] in_offset;
  logic [15:0] in_max_length;
  logic [14:0] in_rune_count;
  logic        in_upcase_flag;
  logic        in_path_flag;
  logic        in_revpath_flag;
  logic        in_unterminated_flag;
  logic        in_unaligned_flag;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_result_kind;
  logic [15:0] out_code_unit;
  logic [15:0] out_bytes_written;
  logic        out_last;

  utf8_to_ucs2_string_writer_unit dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_write_en         (cfg_write_en),
    .cfg_write_data       (cfg_write_data),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_kind              (in_kind),
    .in_data_byte         (in_data_byte),
    .in_offset            (in_offset),
    .in_max_length        (in_max_length),
    .in_rune_count        (in_rune_count),
    .in_upcase_flag       (in_upcase_flag),
    .in_path_flag         (in_path_flag),
    .in_revpath_flag      (in_revpath_flag),
    .in_unterminated_flag (in_unterminated_flag),
    .in_unaligned_flag    (in_unaligned_flag),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_result_kind      (out_result_kind),
    .out_code_unit        (out_code_unit),
    .out_bytes_written    (out_bytes_written),
    .out_last             (out_last)
  );

  // ---------------------------------------------------------------------------
  // shared bookkeeping
  // ---------------------------------------------------------------------------
  wr_result_t  pending_writes[$];   // expected writes, oldest first
  logic [7:0]  string_bytes[$];     // utf-8 bytes of the string being built
  bit          idle_en       = 1'b1;
  bit          hold_request  = 1'b0;
  int unsigned error_count   = 0;
  int unsigned items_sent    = 0;
  int unsigned results_seen  = 0;
  int unsigned strings_open  = 0;
  int unsigned strings_reject = 0;
  int unsigned input_stalls  = 0;
  int unsigned held_off      = 0;

  // ---------------------------------------------------------------------------
  // writer model: decoder, budget and byte count kept alongside the block
  // ---------------------------------------------------------------------------
  bit          m_space  = 1'b0;    // convert_space register
  logic [1:0]  m_pend   = '0;      // continuation bytes still awaited
  logic [20:0] m_acc    = '0;      // rune being assembled
  int unsigned m_held   = 0;       // bytes of the open sequence so far (max 3)
  logic [16:0] m_total  = '0;      // bytes written for the open string
  logic [4:0]  m_flags  = '0;
  bit          m_open   = 1'b0;
  logic [14:0] m_budget = '0;      // code units the string may still take

  function automatic void push_write(input rk_t rk, input logic [15:0] cu,
                                     input logic [15:0] bw, input logic is_last);
    wr_result_t w;
    w.rk      = rk;
    w.cu      = cu;
    w.bw      = bw;
    w.is_last = is_last;
    pending_writes.push_back(w);
  endfunction

  function automatic void reset_decoder();
    m_pend = '0;
    m_acc  = '0;
    m_held = 0;
  endfunction

  // first matching rule wins, so with all three flags every rule still applies
  function automatic logic [20:0] map_char(input logic [20:0] r);
    if (r >= CH_LOWER_A && r <= CH_LOWER_Z && (m_flags & FLAG_UPCASE) != 0)
      return r - CASE_GAP;
    if (r == CH_SLASH && (m_flags & FLAG_REVPATH) != 0)
      return CH_BACKSLASH;
    if (r == CH_BACKSLASH && (m_flags & FLAG_PATH) != 0)
      return CH_SLASH;
    if (r == CH_NBSP && (m_flags & FLAG_REVPATH) != 0 && m_space)
      return CH_SPACE;
    if (r == CH_SPACE && (m_flags & FLAG_PATH) != 0 && m_space)
      return CH_NBSP;
    return r;
  endfunction

  // a rune beyond the budget is dropped and not counted
  function automatic void put_char(input logic [20:0] r);
    logic [20:0] c;
    if (m_budget == 0)
      return;
    m_budget = m_budget - 15'd1;
    c = ((m_flags & FLAG_MAPPING) != 0) ? map_char(r) : r;
    push_write(RK_UNIT, c[15:0], 16'h0, 1'b0);
    m_total = m_total + 17'd2;
  endfunction

  function automatic void lead_byte(input logic [7:0] b);
    if (b < 8'h80) begin
      put_char({13'd0, b});
    end else if (b <= 8'hBF || b >= 8'hF8) begin
      put_char(CH_REPLACE);           // stray continuation or impossible lead
    end else if (b <= 8'hDF) begin
      m_pend = 2'd1;
      m_acc  = {16'd0, b[4:0]};
      m_held = 1;
    end else if (b <= 8'hEF) begin
      m_pend = 2'd2;
      m_acc  = {17'd0, b[3:0]};
      m_held = 1;
    end else begin
      m_pend = 2'd3;
      m_acc  = {18'd0, b[2:0]};
      m_held = 1;
    end
  endfunction

  function automatic void feed_byte(input logic [7:0] b);
    int unsigned n;
    bit          bad;
    logic [20:0] rune;
    if (m_pend == 0) begin
      lead_byte(b);
      return;
    end
    // sequence broken off: one replacement per held byte, then start afresh
    if (b[7:6] != 2'b10) begin
      repeat (m_held) put_char(CH_REPLACE);
      reset_decoder();
      lead_byte(b);
      return;
    end
    m_acc  = {m_acc[14:0], b[5:0]};
    m_pend = m_pend - 2'd1;
    if (m_pend != 0) begin
      if (m_held < 3)
        m_held++;
      return;
    end
    n    = m_held + 1;
    rune = m_acc;
    case (n)
      2:       bad = (rune <= 21'h7F);
      3:       bad = (rune <= 21'h7FF);
      default: bad = (rune <= 21'hFFFF) || (rune > 21'h10FFFF);
    endcase
    reset_decoder();
    // overlong or out of range: one replacement for every byte of it
    if (bad)
      repeat (n) put_char(CH_REPLACE);
    else
      put_char(rune);
  endfunction

  function automatic void model_item(input txn_t t);
    int unsigned need;
    bit          pad;
    case (t.kind)
      KIND_START: begin
        m_flags = t.flags;
        reset_decoder();
        pad  = ((t.flags & FLAG_UNALIGN) == 0) && t.offset[0];
        need = 32'(t.offset) + 2 * 32'(t.runes) + ((t.flags & FLAG_UNTERM) != 0 ? 0 : 2)
               + (pad ? 1 : 0);
        if (need > 32'(t.max_len)) begin
          m_open   = 1'b0;
          m_budget = '0;
          m_total  = '0;
          strings_reject++;
          push_write(RK_REJECT, 16'h0, 16'h0, 1'b1);
        end else begin
          m_open   = 1'b1;
          m_budget = t.runes;
          m_total  = pad ? 17'd1 : 17'd0;
          strings_open++;
          if (pad)
            push_write(RK_PAD, 16'h0, 16'h0, 1'b0);
        end
      end
      KIND_BYTE: begin
        if (m_open)
          feed_byte(t.data);
      end
      KIND_END: begin
        if (m_open) begin
          // an unfinished sequence flushes as replacements
          repeat (m_held) put_char(CH_REPLACE);
          reset_decoder();
          if ((m_flags & FLAG_UNTERM) == 0) begin
            push_write(RK_UNIT, 16'h0, 16'h0, 1'b0);
            m_total = m_total + 17'd2;
          end
          push_write(RK_DONE, 16'h0, m_total[15:0], 1'b1);
          m_open = 1'b0;
        end
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // clock, watchdog, receiver and result checking
  // ---------------------------------------------------------------------------
  initial begin : clock_gen
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ends the run if neither channel moves for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        quiet = 0;
      else
        quiet++;
    end
    $display("timeout: no transaction for %0d cycles, %0d writes outstanding",
             quiet, pending_writes.size());
    $display("utf8_to_ucs2_string_writer_unit: mismatch");
    $finish;
  end

  // receiver: random stall bursts, or one long hold-off on request
  initial begin : receiver_stall
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_stall <= 1'b1;
        held_off = 0;
        while (held_off < HOLD_CYCLES) begin
          @(negedge clk);
          held_off++;
        end
        hold_request = 1'b0;
      end else if (idle_en && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(0, 4)) @(negedge clk);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  function automatic void log_error(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS)
      $display("error at %0t: %s", $time, msg);
  endfunction

  // every accepted write is compared with the oldest expectation
  initial begin : write_checker
    wr_result_t w;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        results_seen++;
        if (pending_writes.size() == 0) begin
          log_error($sformatf("unexpected write kind %0d unit %h count %0d last %0b",
                              out_result_kind, out_code_unit, out_bytes_written, out_last));
        end else begin
          w = pending_writes.pop_front();
          if (out_result_kind !== w.rk || out_code_unit !== w.cu ||
              out_bytes_written !== w.bw || out_last !== w.is_last)
            log_error($sformatf({"write %0d: kind %0d/%0d unit %h/%h count %0d/%0d ",
                                 "last %0b/%0b (expected/actual)"},
                                results_seen, w.rk, out_result_kind, w.cu, out_code_unit,
                                w.bw, out_bytes_written, w.is_last, out_last));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  // unused fields carry noise so every payload bit moves
  function automatic txn_t make_item(input logic [1:0] kind, input logic [7:0] b);
    txn_t        t;
    logic [63:0] noise;
    noise  = {$urandom, $urandom};
    t      = noise[$bits(txn_t)-1:0];
    t.kind = kind;
    t.data = b;
    return t;
  endfunction

  function automatic txn_t make_start(input logic [15:0] off, input logic [15:0] lim,
                                      input logic [14:0] rc, input logic [4:0] fl);
    txn_t t;
    t         = make_item(KIND_START, 8'($urandom));
    t.offset  = off;
    t.max_len = lim;
    t.runes   = rc;
    t.flags   = fl;
    return t;
  endfunction

  function automatic void encode_rune(input logic [20:0] r);
    if (r < 21'h80) begin
      string_bytes.push_back(r[7:0]);
    end else if (r < 21'h800) begin
      string_bytes.push_back({3'b110, r[10:6]});
      string_bytes.push_back({2'b10, r[5:0]});
    end else if (r < 21'h10000) begin
      string_bytes.push_back({4'b1110, r[15:12]});
      string_bytes.push_back({2'b10, r[11:6]});
      string_bytes.push_back({2'b10, r[5:0]});
    end else begin
      string_bytes.push_back({5'b11110, r[20:18]});
      string_bytes.push_back({2'b10, r[17:12]});
      string_bytes.push_back({2'b10, r[11:6]});
      string_bytes.push_back({2'b10, r[5:0]});
    end
  endfunction

  // drives one transaction at the falling edge and waits for its acceptance;
  // returns on the falling edge after it, with valid still high
  task automatic send_item(input txn_t t);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_valid             <= 1'b1;
    in_kind              <= t.kind;
    in_data_byte         <= t.data;
    in_offset            <= t.offset;
    in_max_length        <= t.max_len;
    in_rune_count        <= t.runes;
    in_upcase_flag       <= t.flags[0];
    in_path_flag         <= t.flags[1];
    in_revpath_flag      <= t.flags[2];
    in_unterminated_flag <= t.flags[3];
    in_unaligned_flag    <= t.flags[4];
    @(posedge clk);
    while (in_stall) begin
      input_stalls++;
      @(posedge clk);
    end
    model_item(t);
    items_sent++;
    @(negedge clk);
  endtask

  // lowers valid and waits for every expected write, then for the pipeline
  task automatic drain_writes();
    in_valid <= 1'b0;
    while (pending_writes.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // register is only touched once the block has gone quiet
  task automatic write_space_cfg(input bit v);
    drain_writes();
    cfg_write_en   <= 1'b1;
    cfg_write_data <= v;
    @(negedge clk);
    cfg_write_en   <= 1'b0;
    m_space = v;
  endtask

  task automatic send_bytes(input logic [7:0] b[$]);
    foreach (b[i]) send_item(make_item(KIND_BYTE, b[i]));
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  // items with no open string, rejection at the extremes, exact fit with pad,
  // restart while open and a rune past the budget
  task automatic test_string_framing();
    send_item(make_item(KIND_BYTE, 8'h41));
    send_item(make_item(KIND_END, 8'h00));
    send_item(make_item(KIND_UNUSED, 8'h00));
    send_item(make_start(16'hFFFF, 16'hFFFF, 15'h7FFF, 5'h1F));
    send_item(make_item(KIND_BYTE, 8'hFF));
    send_item(make_start(16'd1, 16'd10, 15'd3, 5'h00));
    send_item(make_start(16'd0, 16'd0, 15'd0, FLAG_UNTERM));
    send_item(make_item(KIND_BYTE, 8'h78));
    send_item(make_item(KIND_END, 8'h00));
    drain_writes();
  endtask

  // every mapping rule, with space conversion switched on
  task automatic test_char_mapping();
    write_space_cfg(1'b1);
    send_item(make_start(16'd2, 16'hFFFF, 15'd7, FLAG_MAPPING));
    send_bytes('{8'h61, 8'h7A, 8'h2F, 8'h5C, 8'h20, 8'hC2, 8'hA0});
    send_item(make_item(KIND_END, 8'h00));
    drain_writes();
  endtask

  // zero byte, bad lead, stray continuation, broken sequence, overlong,
  // beyond the code space and an unfinished sequence at the end
  task automatic test_malformed_input();
    send_item(make_start(16'd0, 16'hFFFF, 15'd16, 5'h00));
    send_bytes('{8'h00, 8'hFF, 8'h80, 8'hE2, 8'h41, 8'hC0, 8'h80,
                 8'hF4, 8'h90, 8'h80, 8'h80, 8'hF0, 8'h9F});
    send_item(make_item(KIND_END, 8'h00));
    drain_writes();
  endtask

  // one string: mostly well-formed runes with random content, some noise
  task automatic send_random_string();
    int unsigned nchars;
    int unsigned rc;
    int unsigned need;
    logic [4:0]  fl;
    logic [15:0] off;
    logic [15:0] lim;
    logic [20:0] r;
    string_bytes.delete();
    nchars = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 30) : $urandom_range(0, 8);
    for (int i = 0; i < nchars; i++) begin
      case ($urandom_range(0, 11))
        0, 1: encode_rune(21'($urandom_range(0, 127)));
        2, 3: begin
          // characters that the mapping rules act on
          case ($urandom_range(0, 4))
            0:       r = CH_LOWER_A + 21'($urandom_range(0, 25));
            1:       r = CH_SLASH;
            2:       r = CH_BACKSLASH;
            3:       r = CH_SPACE;
            default: r = CH_NBSP;
          endcase
          encode_rune(r);
        end
        4: encode_rune(21'($urandom_range(32'h80, 32'h7FF)));
        5: encode_rune(21'($urandom_range(32'h800, 32'hFFFF)));
        6: encode_rune(21'($urandom_range(32'h10000, 32'h10FFFF)));
        7: string_bytes.push_back(8'($urandom_range(0, 255)));
        8: begin
          // three-byte sequence cut short
          string_bytes.push_back(8'hE0 | 8'($urandom_range(0, 15)));
          string_bytes.push_back(8'h80 | 8'($urandom_range(0, 63)));
        end
        9: begin
          // overlong two-byte form
          string_bytes.push_back(8'hC0 | 8'($urandom_range(0, 1)));
          string_bytes.push_back(8'h80 | 8'($urandom_range(0, 63)));
        end
        10: begin
          // four bytes beyond the code space
          string_bytes.push_back(8'hF4 | 8'($urandom_range(0, 3)));
          string_bytes.push_back(8'h90 | 8'($urandom_range(0, 15)));
          string_bytes.push_back(8'h80 | 8'($urandom_range(0, 63)));
          string_bytes.push_back(8'h80 | 8'($urandom_range(0, 63)));
        end
        default: string_bytes.push_back(8'h80 | 8'($urandom_range(0, 63)));
      endcase
    end

    // rune count: usually enough, sometimes short of it, now and then huge
    case ($urandom_range(0, 9))
      0:       rc = $urandom_range(0, 32767);
      1, 2:    rc = (nchars > 2) ? nchars - $urandom_range(1, 2) : 0;
      default: rc = nchars + $urandom_range(0, 3);
    endcase
    fl  = 5'($urandom_range(0, 31));
    off = ($urandom_range(0, 5) == 0) ? 16'($urandom) : 16'($urandom_range(0, 300));
    need = 32'(off) + 2 * rc + ((fl & FLAG_UNTERM) != 0 ? 0 : 2)
           + ((((fl & FLAG_UNALIGN) == 0) && off[0]) ? 1 : 0);

    // limit around the fit boundary so both sides of it are hit
    case ($urandom_range(0, 7))
      0:       lim = 16'($urandom);
      1:       lim = (need > 0 && need <= 32'h10000) ? 16'(need - 1) : 16'($urandom);
      2:       lim = (need <= 32'hFFFF) ? 16'(need) : 16'($urandom);
      default: lim = (need + 400 <= 32'hFFFF) ? 16'(need + $urandom_range(0, 400)) : 16'hFFFF;
    endcase

    send_item(make_start(off, lim, 15'(rc), fl));
    foreach (string_bytes[i]) begin
      if ($urandom_range(0, 39) == 0)
        send_item(make_item(KIND_UNUSED, 8'($urandom)));
      send_item(make_item(KIND_BYTE, string_bytes[i]));
    end
    // sometimes the next start cuts this string off
    if ($urandom_range(0, 11) != 0)
      send_item(make_item(KIND_END, 8'($urandom)));
    // stray items with no string open
    if ($urandom_range(0, 7) == 0)
      send_item(make_item($urandom_range(0, 1) ? KIND_BYTE : KIND_END, 8'($urandom)));
  endtask

  task automatic test_random_strings(input bit space, input int unsigned n_items);
    int unsigned stop_at;
    write_space_cfg(space);
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) send_random_string();
    drain_writes();
  endtask

  // receiver holds off for a long stretch while the sender keeps offering,
  // so the command queue fills and the input channel stalls
  task automatic test_receiver_hold();
    idle_en      = 1'b0;
    hold_request = 1'b1;
    string_bytes.delete();
    for (int i = 0; i < 24; i++) encode_rune(21'($urandom_range(32'h20, 32'h7E)));
    send_item(make_start(16'd0, 16'hFFFF, 15'd24, 5'($urandom_range(0, 31))));
    send_bytes(string_bytes);
    send_item(make_item(KIND_END, 8'h00));
    drain_writes();
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin : main_sequence
    rst_n                = 1'b0;
    cfg_write_en         = 1'b0;
    cfg_write_data       = 1'b0;
    in_valid             = 1'b0;
    in_kind              = KIND_START;
    in_data_byte         = '0;
    in_offset            = '0;
    in_max_length        = '0;
    in_rune_count        = '0;
    in_upcase_flag       = 1'b0;
    in_path_flag         = 1'b0;
    in_revpath_flag      = 1'b0;
    in_unterminated_flag = 1'b0;
    in_unaligned_flag    = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_string_framing();
    test_char_mapping();
    test_malformed_input();
    test_random_strings(1'b0, 80);
    test_random_strings(1'b1, 80);
    test_receiver_hold();
    // closing stretch at full rate on both sides
    idle_en = 1'b0;
    test_random_strings(1'b0, 80);

    $display("covered %0d input transactions: %0d strings written, %0d rejected, %0d writes checked",
             items_sent, strings_open, strings_reject, results_seen);
    $display("input stalled for %0d cycles, receiver held off once for %0d cycles",
             input_stalls, held_off);
    if (error_count == 0)
      $display("utf8_to_ucs2_string_writer_unit: match");
    else
      $display("utf8_to_ucs2_string_writer_unit: mismatch");
    $finish;
  end

endmodule
